// ----- sv/ptfc_pkg.sv -----
// ptfc_pkg: types, codes and helper functions for the pressure/temperature frame checker
// used by ptfc_ctrl, ptfc_datapath and pressure_temp_frame_checker; depends on nothing
`default_nettype none

package ptfc_pkg;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CRC       = 2'd1;
	localparam logic [1:0] ST_NOT_READY = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_FRAME_MODE     = 2'd0;
	localparam logic [1:0] CFG_PRESSURE_SCALE = 2'd1;
	localparam logic [1:0] CFG_SENSOR_READY   = 2'd2;

	localparam int CFG_W   = 15;
	localparam int SCALE_W = 15;

	// byte positions inside a frame
	localparam logic [2:0] POS_P_HI  = 3'd0;
	localparam logic [2:0] POS_P_LO  = 3'd1;
	localparam logic [2:0] POS_P_CRC = 3'd2;
	localparam logic [2:0] POS_T_HI  = 3'd3;
	localparam logic [2:0] POS_T_LO  = 3'd4;
	localparam logic [2:0] POS_T_CRC = 3'd5;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [SCALE_W-1:0] TEMP_DIV = SCALE_W'(200);

	// ceil(2^20 * 256 / 200), exact for 16-bit magnitudes
	localparam logic [20:0] TEMP_RECIP = 21'd1342178;
	localparam int          TEMP_SHIFT = 20;

	// serial divider: one quotient bit per cycle
	localparam int DIV_STEPS = 24;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_P_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       byte_en;
		logic       restart;
		logic [2:0] pos;
		logic       finish;
		logic       not_ready;
		logic       div_step;
	} cmd_t;

	typedef struct packed {
		logic frame_mode;
		logic sensor_ready;
		logic div_last;
	} sts_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/ptfc_ctrl.sv -----
// ptfc_ctrl: frame sequencer, tracks byte position and steps the pressure divider
// depends on ptfc_pkg
`default_nettype none

module ptfc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          frame_start,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire ptfc_pkg::sts_t sts,
	output ptfc_pkg::cmd_t     cmd
);

	ptfc_pkg::state_t state_q, state_d;
	logic [2:0] pos_q, pos_d;
	logic       open_q, open_d;

	logic       accept;
	logic       take;
	logic [2:0] pos_cur;
	logic       fin;

	assign accept  = in_valid && (state_q == ptfc_pkg::S_IDLE);
	assign take    = accept && (frame_start || open_q);
	assign pos_cur = frame_start ? ptfc_pkg::POS_P_HI : pos_q;
	assign fin     = ((pos_cur == ptfc_pkg::POS_P_CRC) && !sts.frame_mode)
	                 || (pos_cur == ptfc_pkg::POS_T_CRC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptfc_pkg::S_IDLE;
			pos_q   <= ptfc_pkg::POS_P_HI;
			open_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			open_q  <= open_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		open_d  = open_q;
		case (state_q)
			ptfc_pkg::S_IDLE: begin
				if (accept && frame_start && !sts.sensor_ready) begin
					pos_d   = ptfc_pkg::POS_P_HI;
					open_d  = 1'b0;
					state_d = ptfc_pkg::S_DONE;
				end else if (take) begin
					if (fin) begin
						pos_d   = ptfc_pkg::POS_P_HI;
						open_d  = 1'b0;
						state_d = ptfc_pkg::S_P_DIV;
					end else begin
						pos_d  = pos_cur + 3'd1;
						open_d = 1'b1;
					end
				end
			end
			ptfc_pkg::S_P_DIV: begin
				if (sts.div_last) begin
					state_d = ptfc_pkg::S_DONE;
				end
			end
			ptfc_pkg::S_DONE: begin
				if (!out_stall) begin
					state_d = ptfc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptfc_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ptfc_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (accept && frame_start && !sts.sensor_ready) begin
					cmd.not_ready = 1'b1;
				end else if (take) begin
					cmd.byte_en = 1'b1;
					cmd.restart = frame_start;
					cmd.pos     = pos_cur;
					cmd.finish  = fin;
				end
			end
			ptfc_pkg::S_P_DIV: begin
				cmd.div_step = 1'b1;
			end
			ptfc_pkg::S_DONE: begin
				out_valid = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/ptfc_datapath.sv -----
// ptfc_datapath: config registers, crc-8 check, word capture, serial divider, result registers
// depends on ptfc_pkg
`default_nettype none

module ptfc_datapath (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [ptfc_pkg::CFG_W-1:0] cfg_data,
	input  wire logic [7:0]              rx_byte,
	input  wire ptfc_pkg::cmd_t          cmd,
	output ptfc_pkg::sts_t               sts,
	output logic [1:0]                   status,
	output logic signed [23:0]           pressure_q8,
	output logic signed [16:0]           temperature_q8
);

	logic                         frame_mode_q;
	logic [ptfc_pkg::SCALE_W-1:0] scale_q;
	logic                         ready_q;

	logic [7:0]  crc_q;
	logic        fail_q;
	logic        nr_q;
	logic [15:0] pw_q;
	logic [15:0] tw_q;

	logic [23:0]                  num_q;
	logic [ptfc_pkg::SCALE_W-1:0] rem_q;
	logic [23:0]                  quo_q;
	logic [ptfc_pkg::SCALE_W-1:0] dvs_q;
	logic [ptfc_pkg::CNT_W-1:0]   cnt_q;
	logic                         neg_q;
	logic [23:0]                  p_res_q;
	logic [16:0]                  t_res_q;

	logic [7:0]  crc_in;
	logic        fail_in;
	logic        crc_bad;
	logic [7:0]  crc_next;
	logic [15:0] ld_mag;
	logic [15:0] rem_sh;
	logic [16:0] diff;
	logic        ge;
	logic [23:0] quo_d;
	logic [23:0] res;
	logic [15:0] t_mag;
	logic [36:0] t_prod;
	logic [16:0] t_scaled;
	logic [16:0] t_res;

	assign crc_in   = cmd.restart ? ptfc_pkg::CRC_INIT : crc_q;
	assign fail_in  = cmd.restart ? 1'b0 : fail_q;
	assign crc_bad  = (rx_byte != crc_in);
	assign crc_next = ptfc_pkg::crc8_byte(crc_in, rx_byte);

	assign ld_mag  = pw_q[15] ? (~pw_q + 16'd1) : pw_q;

	assign rem_sh = {rem_q, num_q[23]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = !diff[16];
	assign quo_d  = {quo_q[22:0], ge};
	assign res    = neg_q ? (~quo_d + 24'd1) : quo_d;

	// temperature * 256 / 200 as a reciprocal multiply on the magnitude
	assign t_mag    = tw_q[15] ? (~tw_q + 16'd1) : tw_q;
	assign t_prod   = 37'(t_mag) * 37'(ptfc_pkg::TEMP_RECIP);
	assign t_scaled = t_prod[ptfc_pkg::TEMP_SHIFT +: 17];
	assign t_res    = tw_q[15] ? (~t_scaled + 17'd1) : t_scaled;

	assign sts.frame_mode   = frame_mode_q;
	assign sts.sensor_ready = ready_q;
	assign sts.div_last     = (cnt_q == ptfc_pkg::CNT_W'(ptfc_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= 1'b1;
			scale_q      <= ptfc_pkg::SCALE_W'(1);
			ready_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptfc_pkg::CFG_FRAME_MODE:     frame_mode_q <= cfg_data[0];
				ptfc_pkg::CFG_PRESSURE_SCALE: scale_q      <= cfg_data[ptfc_pkg::SCALE_W-1:0];
				ptfc_pkg::CFG_SENSOR_READY:   ready_q      <= cfg_data[0];
				default:                      ready_q      <= ready_q;
			endcase
		end
	end

	// crc and frame flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= ptfc_pkg::CRC_INIT;
			fail_q <= 1'b0;
			nr_q   <= 1'b0;
		end else begin
			if (cmd.not_ready) begin
				nr_q  <= 1'b1;
				crc_q <= ptfc_pkg::CRC_INIT;
			end
			if (cmd.byte_en) begin
				case (cmd.pos)
					ptfc_pkg::POS_P_CRC, ptfc_pkg::POS_T_CRC: begin
						fail_q <= fail_in | crc_bad;
						crc_q  <= ptfc_pkg::CRC_INIT;
					end
					default: begin
						fail_q <= fail_in;
						crc_q  <= crc_next;
					end
				endcase
				if (cmd.finish) begin
					nr_q <= 1'b0;
				end
			end
		end
	end

	// word capture
	always_ff @(posedge clk) begin
		if (cmd.byte_en) begin
			case (cmd.pos)
				ptfc_pkg::POS_P_HI: pw_q <= {rx_byte, 8'h00};
				ptfc_pkg::POS_P_LO: pw_q <= {pw_q[15:8], rx_byte};
				ptfc_pkg::POS_T_HI: tw_q <= {rx_byte, 8'h00};
				ptfc_pkg::POS_T_LO: tw_q <= {tw_q[15:8], rx_byte};
				default:            tw_q <= tw_q;
			endcase
		end
	end

	// serial restoring divider on magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.byte_en && cmd.finish) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + ptfc_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_en && cmd.finish) begin
			num_q   <= {ld_mag, 8'h00};
			rem_q   <= '0;
			quo_q   <= '0;
			neg_q   <= pw_q[15];
			dvs_q   <= (scale_q == '0) ? ptfc_pkg::SCALE_W'(1) : scale_q;
			t_res_q <= (cmd.pos == ptfc_pkg::POS_T_CRC) ? t_res : '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[22:0], 1'b0};
			rem_q <= ge ? diff[ptfc_pkg::SCALE_W-1:0] : rem_sh[ptfc_pkg::SCALE_W-1:0];
			quo_q <= quo_d;
			if (sts.div_last) begin
				p_res_q <= res;
			end
		end
	end

	always_comb begin
		if (nr_q) begin
			status = ptfc_pkg::ST_NOT_READY;
		end else if (fail_q) begin
			status = ptfc_pkg::ST_CRC;
		end else begin
			status = ptfc_pkg::ST_OK;
		end
	end

	assign pressure_q8    = (nr_q || fail_q) ? 24'sd0 : $signed(p_res_q);
	assign temperature_q8 = (nr_q || fail_q) ? 17'sd0 : $signed(t_res_q);

endmodule

`default_nettype wire

// ----- sv/pressure_temp_frame_checker.sv -----
// pressure_temp_frame_checker: top level, sequencer plus datapath; depends on ptfc_pkg,
// ptfc_ctrl and ptfc_datapath
// results: a not-ready start gives its word in the cycle after acceptance; a frame result is valid
// after its last crc byte once the one-bit-per-cycle pressure divider has finished
// throughput: one byte per cycle; no byte is taken while dividing or while a result waits,
// so a new frame is not taken until the last result is accepted; reset clears all control state
`default_nettype none

module pressure_temp_frame_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 rx_byte,
	input  wire logic                       frame_start,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      status,
	output logic signed [23:0]              pressure_q8,
	output logic signed [16:0]              temperature_q8,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [ptfc_pkg::CFG_W-1:0] cfg_data
);

	ptfc_pkg::cmd_t cmd;
	ptfc_pkg::sts_t sts;

	ptfc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	ptfc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.pressure_q8    (pressure_q8),
		.temperature_q8 (temperature_q8)
	);

`ifndef SYNTHESIS
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("word accepted while result pending");

	a_not_ready_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && frame_start && !sts.sensor_ready)
		|=> (out_valid && status == ptfc_pkg::ST_NOT_READY))
		else $error("not-ready start gave no result");

	a_bad_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ptfc_pkg::ST_OK) |-> (pressure_q8 == 24'sd0
		&& temperature_q8 == 17'sd0))
		else $error("nonzero fields with error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ptfc_pkg::ST_OK || status == ptfc_pkg::ST_CRC
		|| status == ptfc_pkg::ST_NOT_READY))
		else $error("undefined status code");
`endif

endmodule

`default_nettype wire
